### rtl/utt_pkg.sv
// Shared types, constants and encoding helpers for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [20:0] ReplacementCp = 21'h00fffd;
  localparam logic [20:0] SupplBase     = 21'h010000;

  // Byte counts of one encoded code point
  localparam logic [2:0] Len1 = 3'd1;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  // Bytes taken by the replacement character when it leads a job
  localparam logic [2:0] PrefixLen = 3'd3;

  // One code point to encode, optionally led by a replacement character
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  len;
    logic        prefix;
    logic        eot;
  } job_t;

  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h00007f) begin
      n = Len1;
    end else if (cp <= 21'h0007ff) begin
      n = Len2;
    end else if (cp <= 21'h00ffff) begin
      n = Len3;
    end else begin
      n = Len4;
    end
    return n;
  endfunction

  // Byte number idx of the UTF-8 sequence of cp, len bytes long
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (len)
      Len1: b = cp[7:0];
      Len2: begin
        if (idx == 2'd0) b = {3'b110, cp[10:6]};
      end
      Len3: begin
        if (idx == 2'd0) b = {4'b1110, cp[15:12]};
        else if (idx == 2'd1) b = {2'b10, cp[11:6]};
      end
      Len4: begin
        if (idx == 2'd0) b = {5'b11110, cp[20:18]};
        else if (idx == 2'd1) b = {2'b10, cp[17:12]};
        else if (idx == 2'd2) b = {2'b10, cp[11:6]};
      end
      default: b = {2'b10, cp[5:0]};
    endcase
    return b;
  endfunction

endpackage

### rtl/utt_front.sv
// Front end: accepts code units, pairs surrogates and queues code point jobs.
module utt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          unit_valid_i,
  input  logic [15:0]   unit_i,
  input  logic          last_i,
  input  logic          queue_full_i,
  output logic          unit_ready_o,
  output logic          push_o,
  output utt_pkg::job_t job_o,
  output logic          held_o
);
  import utt_pkg::*;

  logic       held_q, held_d;
  logic [9:0] held_bits_q;
  logic       accept;
  logic       is_high, is_low, pair, main_present;
  logic [20:0] main_cp;

  assign unit_ready_o = !queue_full_i;
  assign accept       = unit_valid_i && unit_ready_o;
  assign held_o       = held_q;

  // Classify the unit against the surrogate ranges
  assign is_high = (unit_i[15:10] == 6'b110110);
  assign is_low  = (unit_i[15:10] == 6'b110111);
  assign pair    = held_q && is_low;

  // Build the job: a held unit not followed by a low surrogate leads with U+FFFD
  always_comb begin
    main_present = 1'b1;
    main_cp      = {5'd0, unit_i};
    if (pair) begin
      main_cp = SupplBase + {1'b0, held_bits_q, unit_i[9:0]};
    end else if (is_high && !last_i) begin
      main_present = 1'b0;
    end else if (is_high || is_low) begin
      main_cp = ReplacementCp;
    end

    job_o.eot = last_i;
    if (!main_present) begin
      job_o.cp     = ReplacementCp;
      job_o.prefix = 1'b0;
    end else begin
      job_o.cp     = main_cp;
      job_o.prefix = held_q && !pair;
    end
    job_o.len = cp_len(job_o.cp);
  end

  assign push_o = accept && (main_present || held_q);

  // Hold a high surrogate until the next unit
  assign held_d = is_high && !last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else if (accept) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_bits_q <= unit_i[9:0];
    end
  end

endmodule

### rtl/utt_fifo.sv
// Short job queue between the front end and the byte sequencer.
module utt_fifo #(
  parameter int unsigned DEPTH = utt_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utt_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output utt_pkg::job_t pop_data_o
);
  import utt_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            store_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = store_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/utt_back.sv
// Back end: walks each job one byte per cycle into the output register, unless the output stalls.
module utt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  utt_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_eot_o
);
  import utt_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q, eot_q;
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] total;
  logic [1:0] main_idx;
  logic       adv, last_byte;
  logic [7:0] next_byte;

  assign total     = job_i.len + (job_i.prefix ? PrefixLen : 3'd0);
  assign last_byte = (cnt_q == total - 3'd1);
  assign adv       = job_valid_i && (!valid_q || out_ready_i);
  assign pop_o     = adv && last_byte;
  assign main_idx  = job_i.prefix ? 2'(cnt_q - PrefixLen) : cnt_q[1:0];

  // Pick the replacement byte or the code point byte
  always_comb begin
    if (job_i.prefix && (cnt_q < PrefixLen)) begin
      next_byte = enc_byte(ReplacementCp, Len3, cnt_q[1:0]);
    end else begin
      next_byte = enc_byte(job_i.cp, job_i.len, main_idx);
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (adv) begin
      cnt_d   = last_byte ? 3'd0 : cnt_q + 3'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // Load the output register on each advance
  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= next_byte;
      last_q <= last_byte;
      eot_q  <= last_byte && job_i.eot;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_eot_o   = eot_q;

endmodule

### rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder top level.
// The job of a unit is written into the job queue; its first byte is then loaded into the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the byte sequencer; a code unit
// yields zero to six bytes (1 to 4 bytes, plus 3 for a leading U+FFFD).
// Reset: asynchronous, active low; clears the held surrogate, the job queue
// and the output register.
module utf16_to_utf8_transcoder #(
  parameter int unsigned FIFO_DEPTH = utt_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] code_unit
  input  logic        s_axis_tlast_i,  // last_unit
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic        m_axis_tlast_o,  // last_in_run
  output logic [0:0]  m_axis_tuser_o   // [0] end_of_text
);
  import utt_pkg::*;

  logic push, queue_full, job_valid, pop, held;
  job_t push_job, head_job;

  utt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .unit_valid_i (s_axis_tvalid_i),
    .unit_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .queue_full_i (queue_full),
    .unit_ready_o (s_axis_tready_o),
    .push_o       (push),
    .job_o        (push_job),
    .held_o       (held)
  );

  utt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (head_job)
  );

  utt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_eot_o   (m_axis_tuser_o[0])
  );

`ifndef SYNTHESIS
  // No surrogate stays held across the end of a text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !held)
    else $error("surrogate held past end of text");

  // End of text only marks the last byte of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tlast_o)
    else $error("end of text without end of run");

  // A queued job fills an empty output slot in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid && !m_axis_tvalid_o) |=> m_axis_tvalid_o)
    else $error("sequencer stalled with a free output slot");
`endif

endmodule
